/* rtl/tq_pkg.sv */
// Shared types, constants and rounding helpers for the TRIAD attitude quaternion block.
package tq_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int FRAME_W     = 16;
  localparam int QUAT_W      = 16;
  localparam int FRAME_FRAC  = 14;
  localparam int QSHIFT      = 14;
  localparam int NORM_SHIFT  = 28;
  localparam int OPND_W      = 18;
  localparam int PROD_W      = 36;
  localparam int ACC_W       = 36;
  localparam int CROSS_W     = 33;
  localparam int CMAG_W      = 32;
  localparam int PRESC_W     = 16;
  localparam int PAIR_W      = 18;
  localparam int DIAG_W      = 19;
  localparam int DIV_DVD_W   = 48;
  localparam int DIV_DVR_W   = 32;
  localparam int SQRT_IN_W   = 64;
  localparam int SQRT_OUT_W  = 32;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;
  localparam int CFG_ADDR_W  = 3;
  localparam int NUM_REGS    = 6;

  localparam logic [63:0] SAT_LIM = 64'd1 << (FRAME_W - 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [FRAME_W-1:0]  frame_t;
  typedef logic signed [QUAT_W-1:0]   quat_t;

  typedef struct packed {
    sample_t ax;
    sample_t ay;
    sample_t az;
    sample_t mx;
    sample_t my;
    sample_t mz;
    logic    deg;
  } item_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_REF_AX = 3'd0,
    CFG_REF_AY = 3'd1,
    CFG_REF_AZ = 3'd2,
    CFG_REF_MX = 3'd3,
    CFG_REF_MY = 3'd4,
    CFG_REF_MZ = 3'd5
  } cfg_idx_t;

  localparam sample_t RESET_REF_AX = 16'sd0;
  localparam sample_t RESET_REF_AY = 16'sd0;
  localparam sample_t RESET_REF_AZ = 16'sd2511;
  localparam sample_t RESET_REF_MX = 16'sd4283;
  localparam sample_t RESET_REF_MY = -16'sd1689;
  localparam sample_t RESET_REF_MZ = -16'sd3620;

  localparam frame_t FRAME_ONE = 16'sd16384;
  localparam quat_t  QUAT_ONE  = 16'sd16384;

  typedef enum logic [1:0] {
    BR_TRACE,
    BR_X,
    BR_Y,
    BR_Z
  } branch_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NSQ,
    ST_NCHK,
    ST_NSQRT,
    ST_NDIV_GO,
    ST_NDIV_W,
    ST_CROSS,
    ST_PRESC,
    ST_T3,
    ST_REFSTORE,
    ST_FAIL,
    ST_RMAC,
    ST_QSEL,
    ST_QSQRT,
    ST_QDIV_GO,
    ST_QDIV_W,
    ST_OUT
  } back_state_t;

  // Saturate a sign and magnitude pair to a 16 bit signed value
  function automatic frame_t sat_mag(input logic neg, input logic [63:0] m);
    logic [63:0] negm;
    negm = ~m + 64'd1;
    if (!neg) begin
      return (m >= SAT_LIM) ? FRAME_W'(SAT_LIM - 64'd1) : FRAME_W'(m);
    end else begin
      return (m >= SAT_LIM) ? FRAME_W'(SAT_LIM) : FRAME_W'(negm);
    end
  endfunction

  // Round a Q8.28 sum back to Q2.14, ties away from zero, then saturate
  function automatic frame_t rnd_frac_sat(input logic signed [ACC_W-1:0] a);
    logic [ACC_W:0] m;
    logic [ACC_W:0] q;
    m = a[ACC_W-1] ? ({1'b0, ~a} + (ACC_W+1)'(1)) : {1'b0, a};
    q = (m + ((ACC_W+1)'(1) << (FRAME_FRAC - 1))) >> FRAME_FRAC;
    return sat_mag(a[ACC_W-1], 64'(q));
  endfunction

  // Cyclic successors of a vector component index
  function automatic logic [1:0] nxt1(input logic [1:0] c);
    logic [1:0] r;
    unique case (c)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] nxt2(input logic [1:0] c);
    logic [1:0] r;
    unique case (c)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

/* rtl/triad_attitude_quaternion.sv */
// Top level of the TRIAD attitude solver: front end, queue and solver back end.
//
//  channel  ports                          transfer when
//  -------  -----------------------------  ----------------------------
//  input    start, busy, in_accel_*, in_mag_*   start high and busy low
//  result   out_valid, out_quat_*, out_degenerate  out_valid high, one cycle
//  config   cfg_we, cfg_addr, cfg_wdata    cfg_we high
//
// The front end takes one sample pair per cycle while the 4 entry queue has room.
// A zero vector is flagged on entry; when the idle solver pops it from the head
// of the queue, its identity result is registered out without solving. Other
// pairs are solved with the shared serial divider (up to nine quotients per pair)
// and the serial square root unit (up to three roots per pair).
// After reset, and after every register write, the reference frame is rebuilt
// before the next queued pair starts.
// Results cannot be held off; busy only reflects a full queue.
module triad_attitude_quaternion (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  tq_pkg::sample_t               in_accel_x,
  input  tq_pkg::sample_t               in_accel_y,
  input  tq_pkg::sample_t               in_accel_z,
  input  tq_pkg::sample_t               in_mag_x,
  input  tq_pkg::sample_t               in_mag_y,
  input  tq_pkg::sample_t               in_mag_z,
  input  logic                          cfg_we,
  input  logic [tq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  tq_pkg::sample_t               cfg_wdata,
  output logic                          out_valid,
  output tq_pkg::quat_t                 out_quat_w,
  output tq_pkg::quat_t                 out_quat_x,
  output tq_pkg::quat_t                 out_quat_y,
  output tq_pkg::quat_t                 out_quat_z,
  output logic                          out_degenerate
);
  import tq_pkg::*;

  logic  push, pop, q_empty, q_full;
  item_t wr_item, rd_item;

  tq_front u_front (
    .start      (start),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_accel_z (in_accel_z),
    .in_mag_x   (in_mag_x),
    .in_mag_y   (in_mag_y),
    .in_mag_z   (in_mag_z),
    .q_full     (q_full),
    .busy       (busy),
    .push       (push),
    .item       (wr_item)
  );

  tq_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .empty   (q_empty),
    .full    (q_full)
  );

  tq_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .q_empty        (q_empty),
    .q_item         (rd_item),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_quat_w     (out_quat_w),
    .out_quat_x     (out_quat_x),
    .out_quat_y     (out_quat_y),
    .out_quat_z     (out_quat_z),
    .out_degenerate (out_degenerate)
  );

endmodule

/* rtl/tq_front.sv */
// Input front end: takes a sample pair and flags zero vectors up front.
module tq_front (
  input  logic            start,
  input  tq_pkg::sample_t in_accel_x,
  input  tq_pkg::sample_t in_accel_y,
  input  tq_pkg::sample_t in_accel_z,
  input  tq_pkg::sample_t in_mag_x,
  input  tq_pkg::sample_t in_mag_y,
  input  tq_pkg::sample_t in_mag_z,
  input  logic            q_full,
  output logic            busy,
  output logic            push,
  output tq_pkg::item_t   item
);
  import tq_pkg::*;

  logic accel_zero;
  logic mag_zero;

  // Classify: a zero vector gives no frame
  assign accel_zero = (in_accel_x == '0) && (in_accel_y == '0) && (in_accel_z == '0);
  assign mag_zero   = (in_mag_x == '0) && (in_mag_y == '0) && (in_mag_z == '0);

  // Transfer into the queue whenever there is room
  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    item.ax  = in_accel_x;
    item.ay  = in_accel_y;
    item.az  = in_accel_z;
    item.mx  = in_mag_x;
    item.my  = in_mag_y;
    item.mz  = in_mag_z;
    item.deg = accel_zero || mag_zero;
  end

endmodule

/* rtl/tq_fifo.sv */
// Short item queue between the front end and the solver.
module tq_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tq_pkg::item_t wr_item,
  input  logic          pop,
  output tq_pkg::item_t rd_item,
  output logic          empty,
  output logic          full
);
  import tq_pkg::*;

  item_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign rd_item = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    cnt_nxt    = cnt_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

/* rtl/tq_div.sv */
// Serial restoring divider, one quotient bit per cycle.
module tq_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tq_pkg::DIV_DVD_W-1:0]   dividend,
  input  logic [tq_pkg::DIV_DVR_W-1:0]   divisor,
  output logic                           done,
  output logic [tq_pkg::DIV_DVD_W-1:0]   quot
);
  import tq_pkg::*;

  localparam int CNT_W = $clog2(DIV_DVD_W);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIV_DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_DVR_W-1:0] dvr_r, dvr_nxt;
  logic [DIV_DVR_W-1:0] rem_r, rem_nxt;
  logic [DIV_DVR_W:0]   rem_sh;
  logic                 qbit;

  assign done = done_r;
  assign quot = dvd_r;

  // One shift and trial subtract per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvr_nxt  = dvr_r;
    rem_nxt  = rem_r;
    rem_sh   = {rem_r, dvd_r[DIV_DVD_W-1]};
    qbit     = (rem_sh >= {1'b0, dvr_r});
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dvr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = qbit ? DIV_DVR_W'(rem_sh - {1'b0, dvr_r}) : DIV_DVR_W'(rem_sh);
      dvd_nxt = {dvd_r[DIV_DVD_W-2:0], qbit};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvr_r <= dvr_nxt;
    rem_r <= rem_nxt;
  end

endmodule

/* rtl/tq_sqrt.sv */
// Serial integer square root, one root bit per cycle.
module tq_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tq_pkg::SQRT_IN_W-1:0]    radicand,
  output logic                            done,
  output logic [tq_pkg::SQRT_OUT_W-1:0]   root
);
  import tq_pkg::*;

  localparam int CNT_W = $clog2(SQRT_OUT_W);
  localparam int REM_W = SQRT_OUT_W + 3;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SQRT_IN_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [SQRT_OUT_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;

  assign done = done_r;
  assign root = root_r;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem_sh   = {rem_r[REM_W-3:0], rad_r[SQRT_IN_W-1:SQRT_IN_W-2]};
    trial    = {1'b0, root_r, 2'b01};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[SQRT_OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[SQRT_OUT_W-2:0], 1'b0};
      end
      rad_nxt = {rad_r[SQRT_IN_W-3:0], 2'b00};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(SQRT_OUT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

endmodule

/* rtl/tq_back.sv */
// Solver back end: builds the triads, the rotation matrix and the quaternion.
module tq_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  tq_pkg::sample_t               cfg_wdata,
  input  logic                          q_empty,
  input  tq_pkg::item_t                 q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  output tq_pkg::quat_t                 out_quat_w,
  output tq_pkg::quat_t                 out_quat_x,
  output tq_pkg::quat_t                 out_quat_y,
  output tq_pkg::quat_t                 out_quat_z,
  output logic                          out_degenerate
);
  import tq_pkg::*;

  back_state_t            state_r, state_nxt;
  sample_t                ref_reg_r [NUM_REGS];
  sample_t                ref_reg_nxt [NUM_REGS];
  logic                   pending_r, pending_nxt;
  logic                   ref_mode_r, ref_mode_nxt;
  logic                   phase_r, phase_nxt;
  logic [2:0]             idx_r, idx_nxt;
  logic [1:0]             ri_r, ri_nxt, rj_r, rj_nxt, rk_r, rk_nxt;
  logic [1:0]             slot_r, slot_nxt;
  branch_t                br_r, br_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  sample_t                u_r [3];
  sample_t                u_nxt [3];
  sample_t                v_r [3];
  sample_t                v_nxt [3];
  logic signed [OPND_W-1:0] p_r [3];
  logic signed [OPND_W-1:0] p_nxt [3];
  logic signed [CROSS_W-1:0] c_r [3];
  logic signed [CROSS_W-1:0] c_nxt [3];
  logic [SQRT_OUT_W-1:0]  s_r, s_nxt;
  frame_t                 t1_r [3];
  frame_t                 t1_nxt [3];
  frame_t                 t2_r [3];
  frame_t                 t2_nxt [3];
  frame_t                 t3_r [3];
  frame_t                 t3_nxt [3];
  frame_t                 nref_r [9];
  frame_t                 nref_nxt [9];
  frame_t                 r_r [9];
  frame_t                 r_nxt [9];
  quat_t                  q_r [4];
  quat_t                  q_nxt [4];
  logic                   out_valid_r, out_valid_nxt;
  quat_t                  out_q_r [4];
  quat_t                  out_q_nxt [4];
  logic                   out_deg_r, out_deg_nxt;

  // Shared multiplier
  logic signed [OPND_W-1:0] opa, opb;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  acc_diff;
  logic [1:0]               cidx, ia, ib;
  logic                     sub;
  logic [3:0]               nidx;
  logic [3:0]               ridx;

  // Divider and root unit hookup
  logic                   div_start, div_done;
  logic [DIV_DVD_W-1:0]   div_dvd;
  logic [DIV_DVR_W-1:0]   div_dvr;
  logic [DIV_DVD_W-1:0]   div_quot;
  logic                   sqrt_start, sqrt_done;
  logic [SQRT_IN_W-1:0]   sqrt_rad;
  logic [SQRT_OUT_W-1:0]  sqrt_root;

  // Normalize and prescale helpers
  logic [OPND_W-1:0]      pmag;
  logic [CMAG_W-1:0]      cmag [3];
  logic [CMAG_W-1:0]      cmax;
  logic [5:0]             blen;
  logic [5:0]             pk;

  // Quaternion helpers
  logic signed [PAIR_W-1:0] trace;
  logic signed [DIAG_W-1:0] diag_a;
  logic [DIAG_W-2:0]        diag_clamp;
  branch_t                  br_sel;
  logic signed [PAIR_W-1:0] d57, d62, d13, s13, s57, s62;
  logic signed [PAIR_W-1:0] pair;
  logic [PAIR_W-1:0]        pair_mag;
  logic [1:0]               tgt;
  logic [1:0]               own;

  tq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvr),
    .done     (div_done),
    .quot     (div_quot)
  );

  tq_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  assign out_valid      = out_valid_r;
  assign out_quat_w     = out_q_r[0];
  assign out_quat_x     = out_q_r[1];
  assign out_quat_y     = out_q_r[2];
  assign out_quat_z     = out_q_r[3];
  assign out_degenerate = out_deg_r;

  // Pick multiplier operands for the current step
  always_comb begin
    cidx = idx_r[2:1];
    sub  = idx_r[0];
    ia   = nxt1(cidx);
    ib   = nxt2(cidx);
    nidx = ({2'b00, rj_r} << 1) + {2'b00, rj_r} + {2'b00, rk_r};
    opa  = '0;
    opb  = '0;
    unique case (state_r)
      ST_NSQ: begin
        opa = p_r[idx_r[1:0]];
        opb = p_r[idx_r[1:0]];
      end
      ST_CROSS: begin
        opa = OPND_W'(u_r[sub ? ib : ia]);
        opb = OPND_W'(v_r[sub ? ia : ib]);
      end
      ST_T3: begin
        opa = OPND_W'(t1_r[sub ? ib : ia]);
        opb = OPND_W'(t2_r[sub ? ia : ib]);
      end
      ST_RMAC: begin
        priority if (rk_r == 2'd0) begin
          opa = OPND_W'(t1_r[ri_r]);
        end else if (rk_r == 2'd1) begin
          opa = OPND_W'(t2_r[ri_r]);
        end else begin
          opa = OPND_W'(t3_r[ri_r]);
        end
        opb = OPND_W'(nref_r[nidx]);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod     = opa * opb;
  assign acc_sum  = acc_r + prod;
  assign acc_diff = acc_r - prod;
  assign ridx     = ({2'b00, ri_r} << 1) + {2'b00, ri_r} + {2'b00, rj_r};

  // Magnitude of the working component for normalization
  assign pmag = p_r[idx_r[1:0]][OPND_W-1] ? OPND_W'(-p_r[idx_r[1:0]])
                                           : OPND_W'(p_r[idx_r[1:0]]);

  // Prescale the cross product into 16 magnitude bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = c_r[i][CROSS_W-1] ? CMAG_W'(-c_r[i]) : CMAG_W'(c_r[i]);
    end
    cmax = cmag[0];
    if (cmag[1] > cmax) cmax = cmag[1];
    if (cmag[2] > cmax) cmax = cmag[2];
    blen = '0;
    for (int b = 0; b < CMAG_W; b++) begin
      if (cmax[b]) blen = 6'(b + 1);
    end
    pk = (blen > 6'(PRESC_W)) ? (blen - 6'(PRESC_W)) : 6'd0;
  end

  // Rotation matrix terms and branch choice
  always_comb begin
    trace = PAIR_W'(r_r[0]) + PAIR_W'(r_r[4]) + PAIR_W'(r_r[8]);
    d57   = PAIR_W'(r_r[5]) - PAIR_W'(r_r[7]);
    d62   = PAIR_W'(r_r[6]) - PAIR_W'(r_r[2]);
    d13   = PAIR_W'(r_r[1]) - PAIR_W'(r_r[3]);
    s13   = PAIR_W'(r_r[1]) + PAIR_W'(r_r[3]);
    s57   = PAIR_W'(r_r[5]) + PAIR_W'(r_r[7]);
    s62   = PAIR_W'(r_r[6]) + PAIR_W'(r_r[2]);
    priority if (trace > 0) begin
      br_sel = BR_TRACE;
      diag_a = DIAG_W'(trace);
    end else if (r_r[4] > r_r[0] && r_r[4] > r_r[8]) begin
      br_sel = BR_Y;
      diag_a = DIAG_W'(r_r[4]) - DIAG_W'(r_r[0]) - DIAG_W'(r_r[8]);
    end else if (r_r[8] > r_r[0]) begin
      br_sel = BR_Z;
      diag_a = DIAG_W'(r_r[8]) - DIAG_W'(r_r[0]) - DIAG_W'(r_r[4]);
    end else begin
      br_sel = BR_X;
      diag_a = DIAG_W'(r_r[0]) - DIAG_W'(r_r[4]) - DIAG_W'(r_r[8]);
    end
    diag_a     = diag_a + DIAG_W'(FRAME_ONE);
    diag_clamp = diag_a[DIAG_W-1] ? '0 : diag_a[DIAG_W-2:0];
  end

  // Map branch and slot to quaternion component and matrix pair
  always_comb begin
    unique case (br_r)
      BR_TRACE: begin
        own = 2'd0;
        unique case (slot_r)
          2'd0:    begin tgt = 2'd1; pair = d57; end
          2'd1:    begin tgt = 2'd2; pair = d62; end
          default: begin tgt = 2'd3; pair = d13; end
        endcase
      end
      BR_X: begin
        own = 2'd1;
        unique case (slot_r)
          2'd0:    begin tgt = 2'd0; pair = d57; end
          2'd1:    begin tgt = 2'd2; pair = s13; end
          default: begin tgt = 2'd3; pair = s62; end
        endcase
      end
      BR_Y: begin
        own = 2'd2;
        unique case (slot_r)
          2'd0:    begin tgt = 2'd0; pair = d62; end
          2'd1:    begin tgt = 2'd1; pair = s13; end
          default: begin tgt = 2'd3; pair = s57; end
        endcase
      end
      default: begin
        own = 2'd3;
        unique case (slot_r)
          2'd0:    begin tgt = 2'd0; pair = d13; end
          2'd1:    begin tgt = 2'd1; pair = s62; end
          default: begin tgt = 2'd2; pair = s57; end
        endcase
      end
    endcase
    pair_mag = pair[PAIR_W-1] ? PAIR_W'(-pair) : PAIR_W'(pair);
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    ref_reg_nxt   = ref_reg_r;
    pending_nxt   = pending_r;
    ref_mode_nxt  = ref_mode_r;
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    ri_nxt        = ri_r;
    rj_nxt        = rj_r;
    rk_nxt        = rk_r;
    slot_nxt      = slot_r;
    br_nxt        = br_r;
    acc_nxt       = acc_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    p_nxt         = p_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    t3_nxt        = t3_r;
    nref_nxt      = nref_r;
    r_nxt         = r_r;
    q_nxt         = q_r;
    out_valid_nxt = 1'b0;
    out_q_nxt     = out_q_r;
    out_deg_nxt   = out_deg_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dvr       = '0;
    sqrt_start    = 1'b0;
    sqrt_rad      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (pending_r) begin
          // Take a snapshot of the registers; a later write asks for another rebuild
          u_nxt[0]     = ref_reg_r[0];
          u_nxt[1]     = ref_reg_r[1];
          u_nxt[2]     = ref_reg_r[2];
          v_nxt[0]     = ref_reg_r[3];
          v_nxt[1]     = ref_reg_r[4];
          v_nxt[2]     = ref_reg_r[5];
          ref_mode_nxt = 1'b1;
          pending_nxt  = 1'b0;
          state_nxt    = ST_NSQ;
        end else if (!q_empty) begin
          q_pop = 1'b1;
          if (q_item.deg) begin
            out_valid_nxt = 1'b1;
            out_q_nxt[0]  = QUAT_ONE;
            out_q_nxt[1]  = '0;
            out_q_nxt[2]  = '0;
            out_q_nxt[3]  = '0;
            out_deg_nxt   = 1'b1;
          end else begin
            u_nxt[0]     = q_item.ax;
            u_nxt[1]     = q_item.ay;
            u_nxt[2]     = q_item.az;
            v_nxt[0]     = q_item.mx;
            v_nxt[1]     = q_item.my;
            v_nxt[2]     = q_item.mz;
            ref_mode_nxt = 1'b0;
            state_nxt    = ST_NSQ;
          end
        end
        for (int i = 0; i < 3; i++) begin
          p_nxt[i] = OPND_W'(u_nxt[i]);
        end
        phase_nxt = 1'b0;
        idx_nxt   = '0;
        acc_nxt   = '0;
      end

      ST_NSQ: begin
        acc_nxt = acc_sum;
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd2) begin
          state_nxt = ST_NCHK;
        end
      end

      ST_NCHK: begin
        if (acc_r == '0) begin
          state_nxt = ST_FAIL;
        end else begin
          sqrt_start = 1'b1;
          sqrt_rad   = SQRT_IN_W'($unsigned(acc_r)) << NORM_SHIFT;
          state_nxt  = ST_NSQRT;
        end
      end

      ST_NSQRT: begin
        if (sqrt_done) begin
          s_nxt     = sqrt_root;
          idx_nxt   = '0;
          state_nxt = ST_NDIV_GO;
        end
      end

      ST_NDIV_GO: begin
        div_start = 1'b1;
        div_dvd   = (DIV_DVD_W'(pmag) << NORM_SHIFT) + DIV_DVD_W'(s_r >> 1);
        div_dvr   = DIV_DVR_W'(s_r);
        state_nxt = ST_NDIV_W;
      end

      ST_NDIV_W: begin
        if (div_done) begin
          if (phase_r) begin
            t2_nxt[idx_r[1:0]] = sat_mag(p_r[idx_r[1:0]][OPND_W-1], 64'(div_quot));
          end else begin
            t1_nxt[idx_r[1:0]] = sat_mag(p_r[idx_r[1:0]][OPND_W-1], 64'(div_quot));
          end
          if (idx_r == 3'd2) begin
            idx_nxt   = '0;
            acc_nxt   = '0;
            state_nxt = phase_r ? ST_T3 : ST_CROSS;
          end else begin
            idx_nxt   = idx_r + 3'd1;
            state_nxt = ST_NDIV_GO;
          end
        end
      end

      ST_CROSS: begin
        if (!sub) begin
          acc_nxt = prod;
        end else begin
          c_nxt[cidx] = CROSS_W'(acc_diff);
        end
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd5) begin
          state_nxt = ST_PRESC;
        end
      end

      ST_PRESC: begin
        for (int i = 0; i < 3; i++) begin
          p_nxt[i] = c_r[i][CROSS_W-1] ? -OPND_W'(cmag[i] >> pk) : OPND_W'(cmag[i] >> pk);
        end
        phase_nxt = 1'b1;
        idx_nxt   = '0;
        acc_nxt   = '0;
        state_nxt = ST_NSQ;
      end

      ST_T3: begin
        if (!sub) begin
          acc_nxt = prod;
        end else begin
          t3_nxt[cidx] = rnd_frac_sat(acc_diff);
        end
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd5) begin
          acc_nxt   = '0;
          ri_nxt    = '0;
          rj_nxt    = '0;
          rk_nxt    = '0;
          state_nxt = ref_mode_r ? ST_REFSTORE : ST_RMAC;
        end
      end

      ST_REFSTORE: begin
        for (int i = 0; i < 3; i++) begin
          nref_nxt[3*i]     = t1_r[i];
          nref_nxt[3*i + 1] = t2_r[i];
          nref_nxt[3*i + 2] = t3_r[i];
        end
        state_nxt = ST_IDLE;
      end

      ST_FAIL: begin
        if (ref_mode_r) begin
          for (int i = 0; i < 9; i++) begin
            nref_nxt[i] = (i % 4 == 0) ? FRAME_ONE : '0;
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_q_nxt[0]  = QUAT_ONE;
          out_q_nxt[1]  = '0;
          out_q_nxt[2]  = '0;
          out_q_nxt[3]  = '0;
          out_deg_nxt   = 1'b1;
        end
        state_nxt = ST_IDLE;
      end

      ST_RMAC: begin
        if (rk_r == 2'd2) begin
          r_nxt[ridx] = rnd_frac_sat(acc_sum);
          acc_nxt     = '0;
          rk_nxt      = '0;
          if (rj_r == 2'd2) begin
            rj_nxt = '0;
            if (ri_r == 2'd2) begin
              state_nxt = ST_QSEL;
            end else begin
              ri_nxt = ri_r + 2'd1;
            end
          end else begin
            rj_nxt = rj_r + 2'd1;
          end
        end else begin
          acc_nxt = acc_sum;
          rk_nxt  = rk_r + 2'd1;
        end
      end

      ST_QSEL: begin
        br_nxt     = br_sel;
        sqrt_start = 1'b1;
        sqrt_rad   = SQRT_IN_W'(diag_clamp) << QSHIFT;
        state_nxt  = ST_QSQRT;
      end

      ST_QSQRT: begin
        if (sqrt_done) begin
          s_nxt    = sqrt_root;
          slot_nxt = '0;
          for (int i = 0; i < 4; i++) begin
            q_nxt[i] = '0;
          end
          q_nxt[own] = sat_mag(1'b0, 64'(({1'b0, sqrt_root} + 33'd1) >> 1));
          if (sqrt_root == '0) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_QDIV_GO;
          end
        end
      end

      ST_QDIV_GO: begin
        div_start = 1'b1;
        div_dvd   = (DIV_DVD_W'(pair_mag) << QSHIFT) + DIV_DVD_W'(s_r);
        div_dvr   = DIV_DVR_W'({s_r, 1'b0});
        state_nxt = ST_QDIV_W;
      end

      ST_QDIV_W: begin
        if (div_done) begin
          q_nxt[tgt] = sat_mag(pair[PAIR_W-1], 64'(div_quot));
          if (slot_r == 2'd2) begin
            state_nxt = ST_OUT;
          end else begin
            slot_nxt  = slot_r + 2'd1;
            state_nxt = ST_QDIV_GO;
          end
        end
      end

      ST_OUT: begin
        out_valid_nxt = 1'b1;
        out_q_nxt     = q_r;
        out_deg_nxt   = 1'b0;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Register writes; a write past the list is dropped
    if (cfg_we && (cfg_addr <= CFG_REF_MZ)) begin
      ref_reg_nxt[cfg_addr] = cfg_wdata;
      pending_nxt           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pending_r    <= 1'b1;
      out_valid_r  <= 1'b0;
      ref_reg_r[0] <= RESET_REF_AX;
      ref_reg_r[1] <= RESET_REF_AY;
      ref_reg_r[2] <= RESET_REF_AZ;
      ref_reg_r[3] <= RESET_REF_MX;
      ref_reg_r[4] <= RESET_REF_MY;
      ref_reg_r[5] <= RESET_REF_MZ;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      ref_reg_r   <= ref_reg_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ref_mode_r <= ref_mode_nxt;
    phase_r    <= phase_nxt;
    idx_r      <= idx_nxt;
    ri_r       <= ri_nxt;
    rj_r       <= rj_nxt;
    rk_r       <= rk_nxt;
    slot_r     <= slot_nxt;
    br_r       <= br_nxt;
    acc_r      <= acc_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    p_r        <= p_nxt;
    c_r        <= c_nxt;
    s_r        <= s_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    t3_r       <= t3_nxt;
    nref_r     <= nref_nxt;
    r_r        <= r_nxt;
    q_r        <= q_nxt;
    out_q_r    <= out_q_nxt;
    out_deg_r  <= out_deg_nxt;
  end

endmodule

/* tb/tb_triad_attitude_quaternion.sv */
// Testbench for the TRIAD attitude quaternion block: directed and random pairs, checked by a scoreboard.
`timescale 1ns / 1ps

module tb_triad_attitude_quaternion;
  import tq_pkg::*;

  localparam int  N_ITEMS    = 1150;
  localparam int  N_SETTINGS = 6;
  localparam int  DRAIN_WAIT = 1000;
  localparam longint CYCLE_LIMIT = 6000000;
  // indexes past the last register; writes there must be ignored
  localparam logic [CFG_ADDR_W-1:0] CFG_NONE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_NONE_HI = 3'd7;

  typedef struct {
    quat_t w;
    quat_t x;
    quat_t y;
    quat_t z;
    logic  deg;
  } attitude_t;

  typedef longint vec3_t[3];

  // Scoreboard: holds the reference triad and the queue of expected attitudes
  class attitude_scoreboard;
    longint    ref_regs[6];
    longint    ref_frame[9];
    attitude_t pending_q[$];
    int        n_fail;
    int        n_checked;
    int        n_degenerate;

    function new();
      ref_regs = '{0, 0, 2511, 4283, -1689, -3620};
      n_fail = 0;
      n_checked = 0;
      n_degenerate = 0;
      rebuild_frame();
    endfunction

    function longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint div_near(longint num, longint den);
      longint unsigned q;
      q = ((num < 0 ? -num : num) + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Shift all magnitudes down until the largest fits 16 bits
    function void shrink(input vec3_t c, output vec3_t o);
      longint unsigned m, a;
      int k;
      m = 0;
      k = 0;
      for (int i = 0; i < 3; i++) begin
        a = c[i] < 0 ? -c[i] : c[i];
        if (a > m) m = a;
      end
      while ((m >> k) > 64'hFFFF) k++;
      for (int i = 0; i < 3; i++) begin
        a = (c[i] < 0 ? -c[i] : c[i]) >> k;
        o[i] = c[i] < 0 ? -longint'(a) : longint'(a);
      end
    endfunction

    function bit unit_vec(input vec3_t c, output vec3_t o);
      vec3_t p;
      longint unsigned n, s;
      shrink(c, p);
      n = 0;
      for (int i = 0; i < 3; i++) n += p[i] * p[i];
      o = '{0, 0, 0};
      if (n == 0) return 0;
      s = int_sqrt(n << 28);
      for (int i = 0; i < 3; i++) o[i] = sat16(div_near(p[i] * (64'sd1 << 28), s));
      return 1;
    endfunction

    // Columns t1, t2, t3 as Q2.14, entry 3*i+k is row i column k
    function bit triad(input vec3_t u, input vec3_t v, output longint fr[9]);
      vec3_t t1, t2, t3, pu, pv, c;
      fr = '{default: 0};
      if (!unit_vec(u, t1)) return 0;
      shrink(u, pu);
      shrink(v, pv);
      c[0] = pu[1] * pv[2] - pu[2] * pv[1];
      c[1] = pu[2] * pv[0] - pu[0] * pv[2];
      c[2] = pu[0] * pv[1] - pu[1] * pv[0];
      if (!unit_vec(c, t2)) return 0;
      t3[0] = t1[1] * t2[2] - t1[2] * t2[1];
      t3[1] = t1[2] * t2[0] - t1[0] * t2[2];
      t3[2] = t1[0] * t2[1] - t1[1] * t2[0];
      for (int i = 0; i < 3; i++) begin
        fr[3*i]   = t1[i];
        fr[3*i+1] = t2[i];
        fr[3*i+2] = sat16(div_near(t3[i], 64'sd1 << FRAME_FRAC));
      end
      return 1;
    endfunction

    function void rebuild_frame();
      vec3_t a, m;
      longint fr[9];
      a = '{ref_regs[0], ref_regs[1], ref_regs[2]};
      m = '{ref_regs[3], ref_regs[4], ref_regs[5]};
      if (triad(a, m, fr)) ref_frame = fr;
      else for (int i = 0; i < 9; i++) ref_frame[i] = (i % 4 == 0) ? (64'sd1 << FRAME_FRAC) : 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, sample_t val);
      if (idx >= NUM_REGS) return;
      ref_regs[idx] = val;
      rebuild_frame();
    endfunction

    function longint ratio(longint num, longint s);
      return div_near(num * (64'sd1 << QSHIFT), 2 * s);
    endfunction

    function longint diag_sqrt(longint d);
      longint a;
      a = d + (64'sd1 << FRAME_FRAC);
      if (a < 0) a = 0;
      return int_sqrt(longint'(a) << QSHIFT);
    endfunction

    // Predict the attitude of one accepted sample pair and queue it
    function void note_pair(sample_t ax, sample_t ay, sample_t az,
                            sample_t mx, sample_t my, sample_t mz);
      vec3_t u, v;
      longint b[9], r[9], q[4], s, tr, acc;
      attitude_t e;
      u = '{ax, ay, az};
      v = '{mx, my, mz};
      q = '{0, 0, 0, 0};
      e.deg = 0;
      if (!triad(u, v, b)) begin
        e.deg = 1;
        q[0] = 64'sd1 << QUAT_W - 2;
        n_degenerate++;
      end else begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += b[3*i+k] * ref_frame[3*j+k];
            r[3*i+j] = sat16(div_near(acc, 64'sd1 << FRAME_FRAC));
          end
        tr = r[0] + r[4] + r[8];
        if (tr > 0) begin
          s = int_sqrt(longint'(tr + (64'sd1 << FRAME_FRAC)) << QSHIFT);
          q[0] = div_near(s, 2);
          q[1] = ratio(r[5] - r[7], s);
          q[2] = ratio(r[6] - r[2], s);
          q[3] = ratio(r[1] - r[3], s);
        end else if (r[4] > r[0] && r[4] > r[8]) begin
          s = diag_sqrt(r[4] - r[0] - r[8]);
          q[2] = div_near(s, 2);
          if (s != 0) begin
            q[0] = ratio(r[6] - r[2], s);
            q[1] = ratio(r[1] + r[3], s);
            q[3] = ratio(r[5] + r[7], s);
          end
        end else if (r[8] > r[0]) begin
          s = diag_sqrt(r[8] - r[0] - r[4]);
          q[3] = div_near(s, 2);
          if (s != 0) begin
            q[0] = ratio(r[1] - r[3], s);
            q[1] = ratio(r[6] + r[2], s);
            q[2] = ratio(r[5] + r[7], s);
          end
        end else begin
          s = diag_sqrt(r[0] - r[4] - r[8]);
          q[1] = div_near(s, 2);
          if (s != 0) begin
            q[0] = ratio(r[5] - r[7], s);
            q[2] = ratio(r[1] + r[3], s);
            q[3] = ratio(r[6] + r[2], s);
          end
        end
      end
      e.w = quat_t'(sat16(q[0]));
      e.x = quat_t'(sat16(q[1]));
      e.y = quat_t'(sat16(q[2]));
      e.z = quat_t'(sat16(q[3]));
      pending_q.push_back(e);
    endfunction

    function void check_result(attitude_t got);
      attitude_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected: w=%0d x=%0d y=%0d z=%0d deg=%0b",
                 $time, got.w, got.x, got.y, got.z, got.deg);
        n_fail++;
        return;
      end
      e = pending_q.pop_front();
      n_checked++;
      if (got.w !== e.w) begin
        $display("%0t: quat_w expected %0d actual %0d", $time, e.w, got.w);
        n_fail++;
      end
      if (got.x !== e.x) begin
        $display("%0t: quat_x expected %0d actual %0d", $time, e.x, got.x);
        n_fail++;
      end
      if (got.y !== e.y) begin
        $display("%0t: quat_y expected %0d actual %0d", $time, e.y, got.y);
        n_fail++;
      end
      if (got.z !== e.z) begin
        $display("%0t: quat_z expected %0d actual %0d", $time, e.z, got.z);
        n_fail++;
      end
      if (got.deg !== e.deg) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, e.deg, got.deg);
        n_fail++;
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  sample_t in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  sample_t in_mag_x = '0, in_mag_y = '0, in_mag_z = '0;
  logic    cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  sample_t cfg_wdata = '0;
  logic    out_valid;
  quat_t   out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic    out_degenerate;

  attitude_scoreboard sb = new();
  longint n_cycles = 0;
  int     idle_pct = 0;
  int     n_sent = 0;

  triad_attitude_quaternion u_dut (.*);

  always #5 clk = ~clk;

  // Abort on a hung block
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", n_cycles, sb.pending_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{out_quat_w, out_quat_x, out_quat_y, out_quat_z, out_degenerate});
  end

  // Drive one pair, with random idle cycles ahead of it
  task automatic send_pair(sample_t ax, sample_t ay, sample_t az,
                           sample_t mx, sample_t my, sample_t mz);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    in_mag_x <= mx;
    in_mag_y <= my;
    in_mag_z <= mz;
    do @(posedge clk); while (busy);
    sb.note_pair(ax, ay, az, mx, my, mz);
    n_sent++;
  endtask

  // Hold the sender until every expected result has arrived
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // Write all six references, plus the unused indexes, while idle
  task automatic write_refs(sample_t ax, sample_t ay, sample_t az,
                            sample_t mx, sample_t my, sample_t mz);
    cfg_idx_t idx[6];
    sample_t  val[6];
    idx = '{CFG_REF_AX, CFG_REF_AY, CFG_REF_AZ, CFG_REF_MX, CFG_REF_MY, CFG_REF_MZ};
    val = '{ax, ay, az, mx, my, mz};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= idx[i];
      cfg_wdata <= val[i];
      sb.write_reg(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_addr <= CFG_NONE_LO;
    cfg_wdata <= sample_t'($urandom_range(65535));
    @(posedge clk);
    cfg_addr <= CFG_NONE_HI;
    cfg_wdata <= sample_t'($urandom_range(65535));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic sample_t rnd_sample(int kind);
    case (kind)
      0:       return sample_t'($urandom_range(65535));
      1:       return sample_t'(int'($urandom_range(1200)) - 600);
      default: return sample_t'(int'($urandom_range(20)) - 10);
    endcase
  endfunction

  task automatic send_random();
    sample_t a[3], m[3];
    int kind, pick;
    kind = ($urandom_range(9) < 7) ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
    for (int i = 0; i < 3; i++) begin
      a[i] = rnd_sample(kind);
      m[i] = rnd_sample(kind);
    end
    pick = $urandom_range(99);
    // drop in zero and parallel pairs now and then
    if (pick < 3) a = '{0, 0, 0};
    else if (pick < 6) m = '{0, 0, 0};
    else if (pick < 9) m = a;
    send_pair(a[0], a[1], a[2], m[0], m[1], m[2]);
  endtask

  initial begin
    int per_phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset references, then rotations through each branch
    idle_pct = 35;
    send_pair(0, 0, 2511, 4283, -1689, -3620);
    send_pair(0, 0, -2511, 4283, 1689, 3620);
    send_pair(0, 0, -2511, -4283, -1689, 3620);
    send_pair(0, 0, 2511, -4283, 1689, -3620);
    send_pair(0, 0, 0, 100, 200, 300);
    send_pair(100, -200, 300, 0, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(300, -500, 700, 300, -500, 700);
    send_pair(300, -500, 700, -300, 500, -700);
    send_pair(32767, 32767, 32767, -32768, -32768, 32767);
    send_pair(-32768, -32768, -32768, 32767, -32768, -32768);
    send_pair(-32768, 0, 0, 0, -32768, 0);
    send_pair(32767, -32768, 0, 0, 0, 32767);
    send_pair(1, 0, 0, 0, 1, 0);
    send_pair(1, 1, 1, -1, 1, 0);
    send_pair(0, -1, 0, 0, 0, -1);
    send_pair(-32768, -32768, -32768, -32768, -32768, -32767);
    drain();

    // Random phases, each under its own reference setting
    per_phase = (N_ITEMS - n_sent) / N_SETTINGS;
    for (int ph = 0; ph < N_SETTINGS; ph++) begin
      idle_pct = (ph < 2) ? 35 : (ph < 4) ? 65 : 0;
      case (ph)
        0: write_refs(32767, -32768, 32767, -32768, 32767, 32767);
        1: write_refs(0, 0, 0, 100, 0, 0);
        2: write_refs(-32768, -32768, -32768, 32767, 32767, 32767);
        3: write_refs(200, -300, 400, 200, -300, 400);
        4: write_refs(rnd_sample(0), rnd_sample(0), rnd_sample(0),
                      rnd_sample(0), rnd_sample(0), rnd_sample(0));
        default: write_refs(0, 0, 2511, 4283, -1689, -3620);
      endcase
      for (int i = 0; i < per_phase; i++) send_random();
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d sample pairs (%0d degenerate) over %0d reference settings,",
             n_sent, sb.n_degenerate, N_SETTINGS + 1);
    $display("%0d results checked with sender idling at 35, 65 and 0 percent.", sb.n_checked);
    if (sb.n_fail == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* triad_attitude_quaternion.f */
rtl/tq_pkg.sv
rtl/tq_front.sv
rtl/tq_fifo.sv
rtl/tq_div.sv
rtl/tq_sqrt.sv
rtl/tq_back.sv
rtl/triad_attitude_quaternion.sv
tb/tb_triad_attitude_quaternion.sv
